/* sv/rbd_pkg.sv */
// Shared types and constants for the ring buffer deque.
// No dependencies; imported by every module of the block.
package rbd_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int CMD_W         = 3;
   localparam int DATA_W        = 32;
   localparam int STATUS_W      = 2;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH_FRONT = 3'd0,
      CMD_PUSH_BACK  = 3'd1,
      CMD_POP_FRONT  = 3'd2,
      CMD_POP_BACK   = 3'd3,
      CMD_PEEK_FRONT = 3'd4,
      CMD_PEEK_BACK  = 3'd5
   } rbd_command_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } rbd_status_type;

   typedef struct packed {
      logic capture;
      logic execute;
   } rbd_ctrl_type;

endpackage

/* sv/rbd_ctrl.sv */
// Controller for the ring buffer deque: sequences capture and store access
// and owns the result valid flag. Depends on rbd_pkg.
module rbd_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rbd_pkg::rbd_ctrl_type ctrl
);
   import rbd_pkg::*;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free     = !rsp_valid_ff || rsp_ready;
   assign req_ready    = (state_ff == ST_IDLE);
   assign ctrl.capture = req_valid && (state_ff == ST_IDLE);
   assign ctrl.execute = (state_ff == ST_EXEC) && out_free;
   assign rsp_valid    = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
      if (ctrl.execute) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* sv/rbd_datapath.sv */
// Datapath for the ring buffer deque: command register, head and count,
// entry store with registered read, result registers. Depends on rbd_pkg.
module rbd_datapath #(
   parameter int DEPTH = rbd_pkg::DEPTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  rbd_pkg::rbd_ctrl_type              ctrl,
   input  logic [rbd_pkg::CMD_W-1:0]          req_command,
   input  logic signed [rbd_pkg::DATA_W-1:0]  req_data_in,
   output logic signed [rbd_pkg::DATA_W-1:0]  rsp_data_out,
   output logic [rbd_pkg::STATUS_W-1:0]       rsp_status,
   output logic                               rsp_is_empty,
   output logic                               rsp_is_full,
   output logic [$clog2(DEPTH+1)-1:0]         rsp_fill_level
);
   import rbd_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int SUM_W = CNT_W + 1;
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);
   localparam logic [SUM_W-1:0] DEPTH_SUM = SUM_W'(DEPTH);
   localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(DEPTH - 1);

   logic [CMD_W-1:0]         command_ff;
   logic signed [DATA_W-1:0] data_in_ff;
   logic [IDX_W-1:0]         head_ff, head_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [STATUS_W-1:0]      status_ff, status_in;
   logic signed [DATA_W-1:0] data_out_ff;
   logic [DATA_W-1:0]        entry_mem [DEPTH];

   logic             full, empty;
   logic [IDX_W-1:0] head_inc, head_dec, tail_slot, back_slot, addr;
   logic [SUM_W-1:0] tail_sum, back_sum;
   logic             wr_en, rd_en;

   assign full     = (count_ff == DEPTH_CNT);
   assign empty    = (count_ff == '0);
   assign head_inc = (head_ff == LAST_IDX) ? '0 : head_ff + 1'b1;
   assign head_dec = (head_ff == '0) ? LAST_IDX : head_ff - 1'b1;
   assign tail_sum = SUM_W'(head_ff) + SUM_W'(count_ff);
   assign back_sum = tail_sum - 1'b1;
   assign tail_slot = (tail_sum >= DEPTH_SUM) ? IDX_W'(tail_sum - DEPTH_SUM)
                                              : IDX_W'(tail_sum);
   assign back_slot = (back_sum >= DEPTH_SUM) ? IDX_W'(back_sum - DEPTH_SUM)
                                              : IDX_W'(back_sum);

   always_comb begin
      head_in   = head_ff;
      count_in  = count_ff;
      status_in = STATUS_OK;
      wr_en     = 1'b0;
      rd_en     = 1'b0;
      addr      = head_ff;
      case (command_ff)
         CMD_PUSH_FRONT: begin
            if (full) begin
               status_in = STATUS_FULL;
            end else begin
               wr_en    = 1'b1;
               addr     = head_dec;
               head_in  = head_dec;
               count_in = count_ff + 1'b1;
            end
         end
         CMD_PUSH_BACK: begin
            if (full) begin
               status_in = STATUS_FULL;
            end else begin
               wr_en    = 1'b1;
               addr     = tail_slot;
               count_in = count_ff + 1'b1;
            end
         end
         CMD_POP_FRONT: begin
            if (empty) begin
               status_in = STATUS_EMPTY;
            end else begin
               rd_en    = 1'b1;
               head_in  = head_inc;
               count_in = count_ff - 1'b1;
            end
         end
         CMD_POP_BACK: begin
            if (empty) begin
               status_in = STATUS_EMPTY;
            end else begin
               rd_en    = 1'b1;
               addr     = back_slot;
               count_in = count_ff - 1'b1;
            end
         end
         CMD_PEEK_FRONT: begin
            if (empty) begin
               status_in = STATUS_EMPTY;
            end else begin
               rd_en = 1'b1;
            end
         end
         CMD_PEEK_BACK: begin
            if (empty) begin
               status_in = STATUS_EMPTY;
            end else begin
               rd_en = 1'b1;
               addr  = back_slot;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else if (ctrl.execute) begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.capture) begin
         command_ff <= req_command;
         data_in_ff <= req_data_in;
      end
      if (ctrl.execute) begin
         status_ff <= status_in;
      end
   end

   // single port store: write on push, registered read into the result
   always_ff @(posedge clock) begin
      if (ctrl.execute) begin
         if (wr_en) begin
            entry_mem[addr] <= data_in_ff;
         end
         data_out_ff <= rd_en ? signed'(entry_mem[addr]) : '0;
      end
   end

   assign rsp_data_out   = data_out_ff;
   assign rsp_status     = status_ff;
   assign rsp_is_empty   = empty;
   assign rsp_is_full    = full;
   assign rsp_fill_level = count_ff;

endmodule

/* sv/ring_buffer_deque.sv */
// Ring buffer deque top level: joins the controller and the datapath.
// Depends on rbd_pkg, rbd_ctrl and rbd_datapath.
//
// A double-ended queue of DEPTH signed 32-bit entries. Each request beat
// carries a command (push/pop/peek at front or back) and a value; each one
// returns exactly one response beat with the data read, a status (ok, refused
// because full, refused because empty), empty and full flags and the fill
// level after the step. Refused commands and unused codes leave the contents
// unchanged. An item is first captured from the request and then makes its
// access through the single read/write port of the entry store, whose
// registered read lands directly in the response register. A new request is
// taken while an earlier response still waits; the access then holds until
// that response has been taken. The store needs no clearing after reset.
module ring_buffer_deque #(
   parameter int DEPTH = rbd_pkg::DEPTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [rbd_pkg::CMD_W-1:0]          req_command,
   input  logic signed [rbd_pkg::DATA_W-1:0]  req_data_in,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [rbd_pkg::DATA_W-1:0]  rsp_data_out,
   output logic [rbd_pkg::STATUS_W-1:0]       rsp_status,
   output logic                               rsp_is_empty,
   output logic                               rsp_is_full,
   output logic [$clog2(DEPTH+1)-1:0]         rsp_fill_level
);
   import rbd_pkg::*;

   rbd_ctrl_type ctrl;

   rbd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .ctrl      (ctrl)
   );

   rbd_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .ctrl           (ctrl),
      .req_command    (req_command),
      .req_data_in    (req_data_in),
      .rsp_data_out   (rsp_data_out),
      .rsp_status     (rsp_status),
      .rsp_is_empty   (rsp_is_empty),
      .rsp_is_full    (rsp_is_full),
      .rsp_fill_level (rsp_fill_level)
   );

endmodule

/* sv/rbd_checker.sv */
// Port-level checks for the ring buffer deque, bound to the top level.
// Depends on rbd_pkg and ring_buffer_deque.
module rbd_checker #(
   parameter int DEPTH = rbd_pkg::DEPTH_DEFAULT
) (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic signed [rbd_pkg::DATA_W-1:0]  rsp_data_out,
   input logic [rbd_pkg::STATUS_W-1:0]       rsp_status,
   input logic                               rsp_is_empty,
   input logic                               rsp_is_full,
   input logic [$clog2(DEPTH+1)-1:0]         rsp_fill_level
);
   import rbd_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data_out)
         && $stable(rsp_status) && $stable(rsp_fill_level))
      else $error("response beat changed while stalled");

   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_is_empty == (rsp_fill_level == '0))
         && (rsp_is_full == (rsp_fill_level == CNT_W'(DEPTH))))
      else $error("flags disagree with fill level");

   a_refused_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_FULL |-> rsp_is_full && rsp_data_out == '0)
      else $error("full refusal without a full deque");

   a_refused_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_EMPTY |-> rsp_is_empty && rsp_data_out == '0)
      else $error("empty refusal without an empty deque");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second request taken before the first was executed");

endmodule

bind ring_buffer_deque rbd_checker #(.DEPTH(DEPTH)) u_rbd_checker (.*);
